// ===== rtl/wsdf_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Parse phases, result status codes and shared widths.
// ----------------------------------------------------------------------------
package wsdf_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned LenW    = 16;
	localparam int unsigned AccW    = 17;
	localparam int unsigned KeyW    = 32;
	localparam int unsigned StatusW = 3;

	localparam logic [LenW-1:0] MaxPayloadReset = 16'd8184;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_LEN  = 3'd1,
		PH_EXT  = 3'd2,
		PH_KEY  = 3'd3,
		PH_DATA = 3'd4
	} phase_t;

	typedef logic [StatusW-1:0] status_t;

	localparam status_t ST_PAYLOAD = 3'd0;
	localparam status_t ST_EMPTY   = 3'd1;
	localparam status_t ST_BAD_HDR = 3'd2;
	localparam status_t ST_BAD_OP  = 3'd3;
	localparam status_t ST_TOO_LNG = 3'd4;

	localparam logic [3:0] OP_TEXT  = 4'd1;
	localparam logic [3:0] OP_CLOSE = 4'd8;

	localparam logic [3:0] HDR_FIN_ONLY = 4'b1000;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	localparam logic [AccW-1:0] LEN_SAT       = 17'h1FFFF;
	localparam logic [AccW-1:0] LEN_SHIFT_MAX = 17'd511;

endpackage

// ===== rtl/wsdf_in_if.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer input channel
// Valid/ready channel carrying one received frame byte per item.
// ----------------------------------------------------------------------------
interface wsdf_in_if;
	logic                        valid;
	logic                        ready;
	logic [wsdf_pkg::ByteW-1:0]  data_byte;
	logic                        frame_start;

	modport source (output valid, output data_byte, output frame_start, input ready);
	modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// ===== rtl/wsdf_out_if.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer output channel
// Valid/ready channel carrying one payload byte or status item.
// ----------------------------------------------------------------------------
interface wsdf_out_if;
	logic                       valid;
	logic                       ready;
	logic [wsdf_pkg::ByteW-1:0] payload_byte;
	logic                       close_frame;
	wsdf_pkg::status_t          status;
	logic                       last;

	modport source (output valid, output payload_byte, output close_frame,
		output status, output last, input ready);
	modport sink   (input valid, input payload_byte, input close_frame,
		input status, input last, output ready);
endinterface

// ===== rtl/websocket_frame_deframer_core.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer core
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle while the output is ready; the input register
// and the result register each hand over in the same cycle they are refilled.
// Reset: arst_n clears the parser to idle, max_payload to 8184, and empties
// both registers.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          max_payload_we,
	input  logic [wsdf_pkg::LenW-1:0]     max_payload_data,
	wsdf_in_if.sink                       in_ch,
	wsdf_out_if.source                    out_ch
);

	logic [wsdf_pkg::LenW-1:0]  max_payload_q;

	logic                       valid_s1;
	logic [wsdf_pkg::ByteW-1:0] byte_s1;
	logic                       start_s1;
	logic                       advance;

	wsdf_pkg::phase_t           phase_q, phase_n;
	logic                       close_q, close_n;
	logic                       masked_q, masked_n;
	logic [3:0]                 ext_left_q, ext_left_n;
	logic [wsdf_pkg::AccW-1:0]  len_q, len_n;
	logic [wsdf_pkg::KeyW-1:0]  key_q, key_n;
	logic [2:0]                 key_left_q, key_left_n;
	logic [1:0]                 mpos_q, mpos_n;
	logic [wsdf_pkg::LenW-1:0]  pay_left_q, pay_left_n;

	logic                       len_done;
	logic                       pay_begin;
	logic [wsdf_pkg::ByteW-1:0] key_byte;

	logic                       res_valid;
	logic [wsdf_pkg::ByteW-1:0] res_byte;
	logic                       res_close;
	wsdf_pkg::status_t          res_status;
	logic                       res_last;

	logic                       valid_s2;
	logic [wsdf_pkg::ByteW-1:0] byte_s2;
	logic                       close_s2;
	wsdf_pkg::status_t          status_s2;
	logic                       last_s2;

	assign advance     = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= wsdf_pkg::MaxPayloadReset;
		end else if (max_payload_we) begin
			max_payload_q <= max_payload_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1  <= in_ch.data_byte;
			start_s1 <= in_ch.frame_start;
		end
	end

	always_comb begin
		unique case (mpos_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_n    = phase_q;
		close_n    = close_q;
		masked_n   = masked_q;
		ext_left_n = ext_left_q;
		len_n      = len_q;
		key_n      = key_q;
		key_left_n = key_left_q;
		mpos_n     = mpos_q;
		pay_left_n = pay_left_q;
		len_done   = 1'b0;
		pay_begin  = 1'b0;
		res_valid  = 1'b0;
		res_byte   = '0;
		res_close  = 1'b0;
		res_status = wsdf_pkg::ST_PAYLOAD;
		res_last   = 1'b0;

		if (start_s1) begin
			close_n    = 1'b0;
			masked_n   = 1'b0;
			ext_left_n = '0;
			len_n      = '0;
			key_n      = '0;
			key_left_n = '0;
			mpos_n     = '0;
			pay_left_n = '0;
			phase_n    = wsdf_pkg::PH_IDLE;
			if (byte_s1[7:4] != wsdf_pkg::HDR_FIN_ONLY) begin
				res_valid  = 1'b1;
				res_status = wsdf_pkg::ST_BAD_HDR;
				res_last   = 1'b1;
			end else if (byte_s1[3:0] != wsdf_pkg::OP_TEXT
				&& byte_s1[3:0] != wsdf_pkg::OP_CLOSE) begin
				res_valid  = 1'b1;
				res_status = wsdf_pkg::ST_BAD_OP;
				res_last   = 1'b1;
			end else begin
				close_n = (byte_s1[3:0] == wsdf_pkg::OP_CLOSE);
				phase_n = wsdf_pkg::PH_LEN;
			end
		end else begin
			unique case (phase_q)
				wsdf_pkg::PH_LEN: begin
					masked_n = byte_s1[7];
					if (byte_s1[6:0] == wsdf_pkg::LEN_EXT16) begin
						len_n      = '0;
						ext_left_n = 4'd2;
						phase_n    = wsdf_pkg::PH_EXT;
					end else if (byte_s1[6:0] == wsdf_pkg::LEN_EXT64) begin
						len_n      = '0;
						ext_left_n = 4'd8;
						phase_n    = wsdf_pkg::PH_EXT;
					end else begin
						len_n    = {10'd0, byte_s1[6:0]};
						len_done = 1'b1;
					end
				end
				wsdf_pkg::PH_EXT: begin
					if (len_q > wsdf_pkg::LEN_SHIFT_MAX) begin
						len_n = wsdf_pkg::LEN_SAT;
					end else begin
						len_n = {len_q[8:0], byte_s1};
					end
					ext_left_n = ext_left_q - 4'd1;
					len_done   = (ext_left_n == 4'd0);
				end
				wsdf_pkg::PH_KEY: begin
					key_n      = {key_q[23:0], byte_s1};
					key_left_n = key_left_q - 3'd1;
					pay_begin  = (key_left_n == 3'd0);
				end
				wsdf_pkg::PH_DATA: begin
					mpos_n     = mpos_q + 2'd1;
					pay_left_n = pay_left_q - 16'd1;
					res_valid  = 1'b1;
					res_byte   = byte_s1 ^ key_byte;
					res_close  = close_q;
					res_status = wsdf_pkg::ST_PAYLOAD;
					res_last   = (pay_left_n == '0);
					if (res_last) begin
						phase_n = wsdf_pkg::PH_IDLE;
					end
				end
				default: begin
					phase_n = wsdf_pkg::PH_IDLE;
				end
			endcase
		end

		if (len_done) begin
			if (len_n > {1'b0, max_payload_q}) begin
				phase_n    = wsdf_pkg::PH_IDLE;
				res_valid  = 1'b1;
				res_close  = close_q;
				res_status = wsdf_pkg::ST_TOO_LNG;
				res_last   = 1'b1;
			end else if (masked_n) begin
				key_left_n = 3'd4;
				key_n      = '0;
				phase_n    = wsdf_pkg::PH_KEY;
			end else begin
				key_n     = '0;
				pay_begin = 1'b1;
			end
		end

		if (pay_begin) begin
			if (len_n == '0) begin
				phase_n    = wsdf_pkg::PH_IDLE;
				res_valid  = 1'b1;
				res_close  = close_q;
				res_status = wsdf_pkg::ST_EMPTY;
				res_last   = 1'b1;
			end else begin
				pay_left_n = len_n[wsdf_pkg::LenW-1:0];
				mpos_n     = '0;
				phase_n    = wsdf_pkg::PH_DATA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= wsdf_pkg::PH_IDLE;
			close_q    <= 1'b0;
			masked_q   <= 1'b0;
			ext_left_q <= '0;
			len_q      <= '0;
			key_q      <= '0;
			key_left_q <= '0;
			mpos_q     <= '0;
			pay_left_q <= '0;
		end else if (advance) begin
			phase_q    <= phase_n;
			close_q    <= close_n;
			masked_q   <= masked_n;
			ext_left_q <= ext_left_n;
			len_q      <= len_n;
			key_q      <= key_n;
			key_left_q <= key_left_n;
			mpos_q     <= mpos_n;
			pay_left_q <= pay_left_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			byte_s2   <= res_byte;
			close_s2  <= res_close;
			status_s2 <= res_status;
			last_s2   <= res_last;
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.payload_byte = byte_s2;
	assign out_ch.close_frame  = close_s2;
	assign out_ch.status       = status_s2;
	assign out_ch.last         = last_s2;

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status_s2 != wsdf_pkg::ST_PAYLOAD |-> last_s2)
		else $error("non-payload item without last");

	a_data_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == wsdf_pkg::PH_DATA |-> pay_left_q != '0)
		else $error("payload phase with zero bytes left");

	a_key_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == wsdf_pkg::PH_KEY |-> key_left_q != '0 && key_left_q <= 3'd4)
		else $error("key phase count out of range");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(start_s1))
		else $error("stalled input register lost its item");

endmodule
